/* design/cc20_pkg.sv */
package cc20_pkg;

	// number of column/diagonal double rounds per keystream block
	localparam int DOUBLE_ROUNDS = 10;
	localparam int DR_W = $clog2(DOUBLE_ROUNDS);

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH   = 3'd5;

	// bytes per keystream block
	localparam int BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(BLOCK_BYTES);

	typedef logic [31:0] word_t;

endpackage

/* design/chacha20_stream_cipher.sv */
// a byte that opens a 64-byte block waits while its block is built: load, double rounds,
//   final add, output load
// other bytes leave in the cycle after acceptance, one byte per cycle while out_stall is low and no block is built
// block rate is set by the single add-xor-rotate unit that runs every quarter-round step,
//   one step per cycle; no byte is accepted while a block is generated
// reset: arst_n clears byte position, block counter, config registers and handshakes
module chacha20_stream_cipher
	import cc20_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_SHUF  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]       state_q;
	logic [3:0]       sub_q;
	logic             half_q;
	logic [DR_W-1:0]  dr_q;
	logic [1:0]       col_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      ctr_q;
	logic [31:0]      blk_ctr_q;
	logic [7:0]       data_q;
	logic             last_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [63:0]      key_low_q, key_mid_low_q, key_mid_high_q, key_high_q, nonce_low_q;
	logic [31:0]      nonce_high_q;

	word_t st_q [16];
	word_t st_d [16];
	word_t init_w [16];
	word_t tmp_w [16];

	logic  in_acc;
	logic  out_free;
	logic  sel_odd;
	word_t add_x, add_y, sum_w, mix_w, rot_w;
	logic [7:0] ks_byte;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q      <= '0;
			key_mid_low_q  <= '0;
			key_mid_high_q <= '0;
			key_high_q     <= '0;
			nonce_low_q    <= '0;
			nonce_high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_LOW:      key_low_q      <= cfg_data;
				REG_KEY_MID_LOW:  key_mid_low_q  <= cfg_data;
				REG_KEY_MID_HIGH: key_mid_high_q <= cfg_data;
				REG_KEY_HIGH:     key_high_q     <= cfg_data;
				REG_NONCE_LOW:    nonce_low_q    <= cfg_data;
				REG_NONCE_HIGH:   nonce_high_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// block input state, counter word taken from the block's own copy
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i] = SIGMA[i];
		end
		init_w[4]  = key_low_q[31:0];
		init_w[5]  = key_low_q[63:32];
		init_w[6]  = key_mid_low_q[31:0];
		init_w[7]  = key_mid_low_q[63:32];
		init_w[8]  = key_mid_high_q[31:0];
		init_w[9]  = key_mid_high_q[63:32];
		init_w[10] = key_high_q[31:0];
		init_w[11] = key_high_q[63:32];
		init_w[12] = blk_ctr_q;
		init_w[13] = nonce_low_q[31:0];
		init_w[14] = nonce_low_q[63:32];
		init_w[15] = nonce_high_q;
	end

	// shared add-xor-rotate unit on column 0 (a=0, b=4, c=8, d=12)
	always_comb begin
		sel_odd = sub_q[0];
		add_x   = sel_odd ? st_q[8]  : st_q[0];
		add_y   = sel_odd ? st_q[12] : st_q[4];
		sum_w   = add_x + add_y;
		mix_w   = (sel_odd ? st_q[4] : st_q[12]) ^ sum_w;
		case (sub_q[1:0])
			2'd0:    rot_w = {mix_w[15:0], mix_w[31:16]};
			2'd1:    rot_w = {mix_w[19:0], mix_w[31:20]};
			2'd2:    rot_w = {mix_w[23:0], mix_w[31:24]};
			default: rot_w = {mix_w[24:0], mix_w[31:25]};
		endcase
	end

	// next working state
	always_comb begin
		st_d  = st_q;
		tmp_w = st_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (pos_q == '0)) begin
					st_d     = init_w;
					st_d[12] = ctr_q;
				end
			end
			ST_ROUND: begin
				if (sel_odd) begin
					tmp_w[8] = sum_w;
					tmp_w[4] = rot_w;
				end else begin
					tmp_w[0]  = sum_w;
					tmp_w[12] = rot_w;
				end
				// after a quarter round move the next column into place
				if (sub_q[1:0] == 2'd3) begin
					for (int r = 0; r < 4; r++) begin
						for (int j = 0; j < 4; j++) begin
							st_d[r*4+j] = tmp_w[r*4+((j+1)%4)];
						end
					end
				end else begin
					st_d = tmp_w;
				end
			end
			ST_SHUF: begin
				// row r shifted left by r words, or back
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						if (!half_q) begin
							st_d[r*4+j] = st_q[r*4+((j+r)%4)];
						end else begin
							st_d[r*4+j] = st_q[r*4+((j+4-r)%4)];
						end
					end
				end
			end
			ST_FIN: begin
				// add input state back, one column per cycle
				for (int r = 0; r < 4; r++) begin
					tmp_w[r*4] = st_q[r*4] + init_w[r*4+32'(col_q)];
				end
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						st_d[r*4+j] = tmp_w[r*4+((j+1)%4)];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
	end

	// keystream byte for the current position
	assign ks_byte = st_q[pos_q[POS_W-1:2]][8*pos_q[1:0] +: 8];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sub_q   <= '0;
			half_q  <= 1'b0;
			dr_q    <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (pos_q == '0)) begin
						state_q <= ST_ROUND;
						sub_q   <= '0;
						half_q  <= 1'b0;
						dr_q    <= '0;
					end
				end
				ST_ROUND: begin
					sub_q <= sub_q + 4'd1;
					if (sub_q == 4'd15) begin
						state_q <= ST_SHUF;
					end
				end
				ST_SHUF: begin
					if (!half_q) begin
						half_q  <= 1'b1;
						state_q <= ST_ROUND;
					end else if (dr_q == DR_W'(DOUBLE_ROUNDS - 1)) begin
						state_q <= ST_FIN;
						col_q   <= '0;
					end else begin
						half_q  <= 1'b0;
						dr_q    <= dr_q + 1'b1;
						state_q <= ST_ROUND;
					end
				end
				ST_FIN: begin
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// byte position and block counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ctr_q <= '0;
		end else if (in_acc) begin
			if (last_byte) begin
				pos_q <= '0;
				ctr_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == POS_W'(BLOCK_BYTES - 1)) begin
					ctr_q <= ctr_q + 32'd1;
				end
			end
		end
	end

	// request held while its block is generated
	always_ff @(posedge clk) begin
		if (in_acc && (pos_q == '0)) begin
			blk_ctr_q <= ctr_q;
			data_q    <= data_byte;
			last_q    <= last_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && (pos_q != '0)) begin
			out_valid_q <= 1'b1;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (pos_q != '0)) begin
			out_byte_q <= data_byte ^ ks_byte;
			out_last_q <= last_byte;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_byte_q <= data_q ^ st_q[0][7:0];
			out_last_q <= last_q;
		end
	end

	// block start launches the round sequence
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (pos_q == '0)) |=> ((state_q == ST_ROUND) && (sub_q == 4'd0)))
		else $error("block start did not enter rounds");

	// last final-add column hands over to output
	a_fin_emit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (col_q == 2'd3)) |=> (state_q == ST_EMIT))
		else $error("final add did not reach emit");

	// position steps by one on a non-last byte
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !last_byte) |=> (pos_q == $past(pos_q) + 1'b1))
		else $error("byte position did not advance");

	// a new output comes only from a request or the emit state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_acc || (state_q == ST_EMIT)))
		else $error("output valid without source");

endmodule
